// ----- rtl/drt_pkg.sv -----
// Shared types and constants for the dirty range table.
package drt_pkg;

  localparam int DefMaxRanges = 256;
  localparam logic [15:0] LenSat = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_COMPACT = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_COVERED   = 3'd1,
    ST_ENLARGED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] entry_address;
    logic [15:0] entry_length;
    logic [8:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [23:0] start;
    logic [15:0] length;
  } entry_t;

endpackage

// ----- rtl/drt_mem.sv -----
// Entry store: one write port, one registered read port.
module drt_mem
  import drt_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dirty_range_table.sv -----
// Dirty range table: bounded store of written address ranges.
// Requests arrive on req/req_valid/req_stall; each produces exactly one
// response on rsp/rsp_valid/rsp_stall. One request is worked at a time;
// req_stall is high from acceptance until the response has been taken.
// A sequencer walks a single entry memory with one registered read port;
// each read waits on that registered port. A record scans the entries in
// order until one matches, then appends the range or drops it on a full
// table; a read at or above the count answers without touching memory; a
// clear only zeroes the count; a compact runs an exchange sort, then one
// merge pass, and answers at once with fewer than two entries.
// The next request is taken only after the response has left. Reset
// empties the table at once (count to zero); entries are not cleared.
// A stalled response holds in the output register and the block takes
// no new request until it leaves.
module dirty_range_table
  import drt_pkg::*;
#(
  parameter int MAX_RANGES = DefMaxRanges
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_REC_RD, S_REC_CHK, S_RD_WAIT, S_RD_OUT,
    S_SI_RD, S_SI_WAIT, S_SI_LOAD, S_SJ_WAIT, S_SJ_CMP, S_SI_END,
    S_MI_RD, S_MI_WAIT, S_MI_LOAD, S_MN_WAIT, S_MN_CMP, S_M_END,
    S_RESP
  } state_t;

  state_t      state;
  req_t        cur;
  logic [CW-1:0] count;
  logic [CW-1:0] i, j;
  entry_t      a;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  drt_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [24:0] a_end, b_end;
  logic [24:0] span;
  logic [15:0] merged;
  logic        overlap;
  assign a_end = {1'b0, a.start} + {9'd0, a.length};
  assign b_end = {1'b0, rdata.start} + {9'd0, rdata.length};
  assign span  = b_end - {1'b0, a.start};
  assign overlap = ({1'b0, rdata.start} <= a_end);
  always_comb begin
    if (span > {9'd0, LenSat}) merged = LenSat;
    else merged = span[15:0];
    if (merged < a.length) merged = a.length;
  end

  // memory writes land at the end of the cycle in which they are decided
  always_comb begin
    we    = 1'b0;
    waddr = AW'(i);
    wdata = a;
    case (state)
      S_REC_RD: if (i == count && 32'(count) < MAX_RANGES) begin
        we    = 1'b1;
        waddr = AW'(count);
        wdata = '{start: cur.address, length: cur.length};
      end
      S_REC_CHK: if (rdata.start == cur.address && rdata.length < cur.length) begin
        we    = 1'b1;
        wdata = '{start: cur.address, length: cur.length};
      end
      S_SJ_CMP: if (a.start > rdata.start) begin
        we    = 1'b1;
        waddr = AW'(j);
      end
      S_SI_END, S_M_END: we = 1'b1;
      S_MN_CMP: we = !overlap;
      default: we = 1'b0;
    endcase
  end

  assign req_stall = (state != S_IDLE) || rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: if (req_valid && !req_stall) begin
          cur <= req;
          rsp.entry_address <= '0;
          rsp.entry_length  <= '0;
          i   <= '0;
          case (op_t'(req.op))
            OP_RECORD: begin
              raddr <= '0;
              state <= S_REC_RD;
            end
            OP_COMPACT: begin
              rsp.status <= ST_DONE;
              state <= S_SI_RD;
            end
            OP_READ: begin
              raddr <= AW'(req.index);
              if (32'(req.index) < 32'(count)) begin
                rsp.status <= ST_DONE;
                state <= S_RD_WAIT;
              end else begin
                rsp.status <= ST_BAD_INDEX;
                state <= S_RESP;
              end
            end
            default: begin
              count <= '0;
              rsp.status <= ST_DONE;
              state <= S_RESP;
            end
          endcase
        end
        S_REC_RD: begin
          if (i == count) begin
            if (32'(count) >= MAX_RANGES) rsp.status <= ST_FULL;
            else begin
              count <= count + 1'b1;
              rsp.status <= ST_DONE;
            end
            state <= S_RESP;
          end else state <= S_REC_CHK;
        end
        S_REC_CHK: begin
          if (rdata.start == cur.address) begin
            if (rdata.length >= cur.length) rsp.status <= ST_COVERED;
            else rsp.status <= ST_ENLARGED;
            state <= S_RESP;
          end else begin
            i     <= i + 1'b1;
            raddr <= AW'(i + 1'b1);
            state <= S_REC_RD;
          end
        end
        S_RD_WAIT: state <= S_RD_OUT;
        S_RD_OUT: begin
          rsp.entry_address <= rdata.start;
          rsp.entry_length  <= rdata.length;
          state <= S_RESP;
        end
        // exchange sort: a holds entry i, compared with each later j
        S_SI_RD: begin
          if (32'(i) + 1 >= 32'(count)) begin
            if (32'(count) < 2) state <= S_RESP;
            else state <= S_MI_RD;
          end else begin
            raddr <= AW'(i);
            j     <= i + 1'b1;
            state <= S_SI_WAIT;
          end
        end
        S_SI_WAIT: state <= S_SI_LOAD;
        S_SI_LOAD: begin
          a     <= rdata;
          raddr <= AW'(j);
          state <= S_SJ_WAIT;
        end
        S_SJ_WAIT: state <= S_SJ_CMP;
        S_SJ_CMP: begin
          if (a.start > rdata.start) a <= rdata;
          j <= j + 1'b1;
          if (j + 1'b1 == count) state <= S_SI_END;
          else begin
            raddr <= AW'(j + 1'b1);
            state <= S_SJ_WAIT;
          end
        end
        S_SI_END: begin
          i     <= i + 1'b1;
          state <= S_SI_RD;
        end
        // merge pass: j reads ahead, i is where the next joined entry goes
        S_MI_RD: begin
          raddr <= '0;
          i     <= '0;
          j     <= CW'(1);
          state <= S_MI_WAIT;
        end
        S_MI_WAIT: state <= S_MI_LOAD;
        S_MI_LOAD: begin
          a     <= rdata;
          raddr <= AW'(j);
          state <= S_MN_WAIT;
        end
        S_MN_WAIT: state <= S_MN_CMP;
        S_MN_CMP: begin
          if (overlap) a.length <= merged;
          else begin
            i <= i + 1'b1;
            a <= rdata;
          end
          j <= j + 1'b1;
          if (j + 1'b1 == count) state <= S_M_END;
          else begin
            raddr <= AW'(j + 1'b1);
            state <= S_MN_WAIT;
          end
        end
        S_M_END: begin
          count <= i + 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          rsp.entry_count <= 9'(count);
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/drt_scoreboard.sv -----
// Scoreboard for the dirty range table: predicts each response and checks it.
module drt_scoreboard
  import drt_pkg::*;
#(
  parameter int MAX_RANGES = DefMaxRanges
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  input  logic req_stall,
  input  rsp_t rsp,
  input  logic rsp_valid,
  input  logic rsp_stall,
  output int   errors,
  output int   pending,
  output int   table_count
);

  logic [23:0] shadow_start [MAX_RANGES];
  logic [15:0] shadow_len   [MAX_RANGES];
  int unsigned shadow_count;
  rsp_t        expected_rsps [$];

  function automatic logic [2:0] record_range(logic [23:0] addr, logic [15:0] len);
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_start[i] == addr) begin
        if (shadow_len[i] >= len) return ST_COVERED;
        shadow_len[i] = len;
        return ST_ENLARGED;
      end
    end
    if (shadow_count >= MAX_RANGES) return ST_FULL;
    shadow_start[shadow_count] = addr;
    shadow_len[shadow_count] = len;
    shadow_count++;
    return ST_DONE;
  endfunction

  function automatic void compact_table();
    logic [23:0] ts;
    logic [15:0] tl;
    int unsigned i;
    int unsigned span;
    for (int unsigned a = 0; a + 1 < shadow_count; a++) begin
      for (int unsigned b = a + 1; b < shadow_count; b++) begin
        if (shadow_start[a] > shadow_start[b]) begin
          ts = shadow_start[a]; shadow_start[a] = shadow_start[b]; shadow_start[b] = ts;
          tl = shadow_len[a];   shadow_len[a]   = shadow_len[b];   shadow_len[b]   = tl;
        end
      end
    end
    i = 0;
    while (i + 1 < shadow_count) begin
      if (32'(shadow_start[i + 1]) <= 32'(shadow_start[i]) + 32'(shadow_len[i])) begin
        span = 32'(shadow_start[i + 1]) + 32'(shadow_len[i + 1]) - 32'(shadow_start[i]);
        if (span < 32'(shadow_len[i])) span = 32'(shadow_len[i]);
        if (span > 32'(LenSat)) span = 32'(LenSat);
        shadow_len[i] = span[15:0];
        for (int unsigned j = i + 2; j < shadow_count; j++) begin
          shadow_start[j - 1] = shadow_start[j];
          shadow_len[j - 1] = shadow_len[j];
        end
        shadow_count--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t e;
    e = '0;
    e.status = ST_DONE;
    case (op_t'(r.op))
      OP_RECORD: e.status = record_range(r.address, r.length);
      OP_COMPACT: compact_table();
      OP_READ: begin
        if (r.index < shadow_count) begin
          e.entry_address = shadow_start[r.index];
          e.entry_length = shadow_len[r.index];
        end else begin
          e.status = ST_BAD_INDEX;
        end
      end
      default: shadow_count = 0;
    endcase
    e.entry_count = shadow_count[8:0];
    return e;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      shadow_count = 0;
      expected_rsps.delete();
    end else begin
      if (req_valid && !req_stall) expected_rsps.push_back(predict_response(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            errors++;
          end
          if (rsp.entry_address !== e.entry_address) begin
            $error("entry_address: expected %h, got %h", e.entry_address, rsp.entry_address);
            errors++;
          end
          if (rsp.entry_length !== e.entry_length) begin
            $error("entry_length: expected %h, got %h", e.entry_length, rsp.entry_length);
            errors++;
          end
          if (rsp.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count, rsp.entry_count);
            errors++;
          end
        end
      end
    end
    pending = expected_rsps.size();
    table_count = shadow_count;
  end

endmodule

// ----- tb/sv/tb_dirty_range_table.sv -----
// Top of the dirty range table testbench: stimulus, flow control and verdict.
module tb_dirty_range_table;
  import drt_pkg::*;

  localparam int CycleLimit = 5_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  int   errors, pending, table_count;
  int   cycles = 0;
  bit   calm = 1'b0;
  int   op_seen [4];
  int   rsp_taken = 0;
  logic [23:0] cluster_base;

  always #5 clk = ~clk;

  dirty_range_table dut (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  drt_scoreboard scoreboard (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .errors(errors), .pending(pending), .table_count(table_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("dirty_range_table verification failed");
      $finish;
    end
  end

  // Receiver: random hold-off per response, one long hold to back up the block.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      rsp_taken++;
      if (rsp_taken == 150) begin
        rsp_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
    end
  end

  task automatic send(logic [1:0] op, logic [23:0] addr, logic [15:0] len, logic [7:0] idx);
    int gap;
    req.op <= op;
    req.address <= addr;
    req.length <= len;
    req.index <= idx;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    op_seen[op]++;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [23:0] a;
    logic [15:0] l;
    logic [7:0] ix;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send(OP_READ, '0, '0, 8'd0);
    send(OP_COMPACT, '0, '0, '0);
    send(OP_RECORD, 24'd0, 16'd0, '0);
    send(OP_RECORD, 24'd0, 16'd0, '0);
    send(OP_RECORD, 24'd0, 16'd5, '0);
    send(OP_COMPACT, '0, '0, '0);
    send(OP_RECORD, 24'hFFFFFF, 16'hFFFF, '0);
    send(OP_RECORD, 24'd10, 16'd20, '0);
    send(OP_RECORD, 24'd30, 16'd1, '0);
    send(OP_RECORD, 24'd5, 16'hFFFF, '0);
    send(OP_RECORD, 24'hFFFFFF, 16'd3, '0);
    send(OP_COMPACT, '0, '0, '0);
    send(OP_READ, '0, '0, 8'd0);
    send(OP_READ, '0, '0, 8'd1);
    send(OP_READ, '0, '0, 8'd2);
    send(OP_READ, '0, '0, 8'd255);
    send(OP_CLEAR, '0, '0, '0);
    send(OP_READ, '0, '0, 8'd0);
    send(OP_RECORD, 24'h800000, 16'h8000, '0);
    send(OP_COMPACT, '0, '0, '0);
    drain();

    // fill the table to overflow, then sort and merge it at full size
    calm = 1'b1;
    for (int k = 0; k < 256; k++) send(OP_RECORD, 24'($urandom), 16'($urandom), '0);
    send(OP_RECORD, 24'h123456, 16'd9, '0);
    send(OP_READ, '0, '0, 8'd255);
    send(OP_COMPACT, '0, '0, '0);
    send(OP_READ, '0, '0, 8'($urandom_range(0, 255)));
    send(OP_CLEAR, '0, '0, '0);
    calm = 1'b0;

    cluster_base = 24'($urandom);
    for (int k = 0; k < 570; k++) begin
      if (k % 120 == 60) calm = ~calm;
      if (k == 400) drain();
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) a = 24'($urandom);
      else a = cluster_base + 24'($urandom_range(0, 255));
      l = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      ix = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, table_count));
      if (table_count > 20 || r < 4) begin
        send(OP_CLEAR, '0, '0, '0);
        cluster_base = 24'($urandom);
      end else if (r < 64) send(OP_RECORD, a, l, '0);
      else if (r < 72) send(OP_COMPACT, '0, '0, '0);
      else if (r < 94) send(OP_READ, '0, '0, ix);
      else send(op_t'($urandom_range(0, 3)), 24'($urandom), 16'($urandom), 8'($urandom));
    end
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d records, %0d compactions, %0d reads, %0d clears,",
             op_seen[OP_RECORD], op_seen[OP_COMPACT], op_seen[OP_READ], op_seen[OP_CLEAR]);
    $display("including a full-table overflow and a long response hold-off.");
    if (errors == 0) $display("dirty_range_table verification clean");
    else $display("dirty_range_table verification failed");
    $finish;
  end

endmodule
